// File: rtl/core/bnd_pkg.sv
// Shared types, constants and the symbol lookup of the base-N decoder.
package bnd_pkg;

    localparam int AccW   = 40;
    localparam int QDepth = 4;
    localparam int QPtrW  = 2;
    localparam int QCntW  = 3;

    localparam logic [2:0] MODE_B16    = 3'd0;
    localparam logic [2:0] MODE_B32    = 3'd1;
    localparam logic [2:0] MODE_B32HEX = 3'd2;
    localparam logic [2:0] MODE_B64    = 3'd3;
    localparam logic [2:0] MODE_B64URL = 3'd4;

    localparam logic [7:0] CH_PAD   = 8'h3D; // '='
    localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
    localparam logic [7:0] CH_SLASH = 8'h2F; // '/'
    localparam logic [7:0] CH_DASH  = 8'h2D; // '-'
    localparam logic [7:0] CH_UNDER = 8'h5F; // '_'

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_LENGTH  = 2'd2,
        ST_PADDING = 2'd3
    } t_status;

    // One decoded group, or a bare message end, handed from front to back.
    typedef struct packed {
        logic [AccW-1:0] acc;
        logic [5:0]      total;
        logic [2:0]      nbytes;
        logic            last;
        t_status         status;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Returns {hit, value}; hit is low for characters outside the alphabet.
    function automatic logic [6:0] sym_lookup(input logic [2:0] m, input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (!c[7]) begin
            case (m)
                MODE_B16: begin
                    if (c inside {[8'h30:8'h39]}) r = {1'b1, 6'(c - 8'h30)};
                    else if (c inside {[8'h41:8'h46]}) r = {1'b1, 6'(c - 8'h41 + 8'd10)};
                end
                MODE_B32: begin
                    if (c inside {[8'h41:8'h5A]}) r = {1'b1, 6'(c - 8'h41)};
                    else if (c inside {[8'h32:8'h37]}) r = {1'b1, 6'(c - 8'h32 + 8'd26)};
                end
                MODE_B32HEX: begin
                    if (c inside {[8'h30:8'h39]}) r = {1'b1, 6'(c - 8'h30)};
                    else if (c inside {[8'h41:8'h56]}) r = {1'b1, 6'(c - 8'h41 + 8'd10)};
                end
                default: begin
                    if (c inside {[8'h41:8'h5A]}) r = {1'b1, 6'(c - 8'h41)};
                    else if (c inside {[8'h61:8'h7A]}) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
                    else if (c inside {[8'h30:8'h39]}) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
                    else if (m == MODE_B64URL) begin
                        if (c == CH_DASH) r = {1'b1, 6'd62};
                        else if (c == CH_UNDER) r = {1'b1, 6'd63};
                    end else begin
                        if (c == CH_PLUS) r = {1'b1, 6'd62};
                        else if (c == CH_SLASH) r = {1'b1, 6'd63};
                    end
                end
            endcase
        end
        return r;
    endfunction

endpackage

// File: rtl/core/bnd_if.sv
// Channel interfaces of the base-N decoder: text in, bytes out, mode write.
interface bnd_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_symbol;
    modport source (output valid, symbol, last_symbol, input ready);
    modport sink   (input valid, symbol, last_symbol, output ready);
endinterface

interface bnd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_end;
    logic [1:0] status;
    modport source (output valid, data_byte, byte_valid, run_last, message_end, status,
                     input ready);
    modport sink   (input valid, data_byte, byte_valid, run_last, message_end, status,
                     output ready);
endinterface

interface bnd_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] alphabet_mode;
    modport source (output valid, alphabet_mode, input ready);
    modport sink   (input valid, alphabet_mode, output ready);
endinterface

// File: rtl/core/bnd_front.sv
// Front end: takes characters, tracks group and padding state, emits group jobs.
module bnd_front
    import bnd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    bnd_sym_if.sink      i_sym,
    bnd_cfg_if.sink      i_cfg,
    input  t_qstat       i_qstat,
    output logic         o_push,
    output t_job         o_job
);

    logic [2:0]      r_mode;
    logic [AccW-1:0] r_acc;
    logic [2:0]      r_cnt;
    logic [2:0]      r_pad;
    logic            r_closed;
    t_status         r_err;

    logic [AccW-1:0] n_acc;
    logic [2:0]      n_cnt;
    logic [2:0]      n_pad;
    logic            n_closed;
    t_status         n_err;

    logic [2:0]      m;
    logic [2:0]      bits;
    logic [3:0]      glen;
    logic [6:0]      lk;
    logic [3:0]      cnt1;
    logic [3:0]      np1;
    logic [3:0]      d;
    logic [5:0]      total;
    logic [2:0]      nb;
    logic [AccW-1:0] job_acc;
    logic            take;

    assign i_cfg.ready = 1'b1;
    // Hold items off while a mode write lands.
    assign i_sym.ready = !i_qstat.full && !i_cfg.valid;
    assign take        = i_sym.valid && i_sym.ready;

    always_comb begin
        m = (r_mode > MODE_B64URL) ? MODE_B64 : r_mode;
        case (m)
            MODE_B16:                 begin bits = 3'd4; glen = 4'd2; end
            MODE_B32, MODE_B32HEX:    begin bits = 3'd5; glen = 4'd8; end
            default:                  begin bits = 3'd6; glen = 4'd4; end
        endcase
        lk       = sym_lookup(m, i_sym.symbol);
        cnt1     = {1'b0, r_cnt} + 4'd1;
        np1      = {1'b0, r_pad} + 4'd1;
        d        = 4'd0;
        total    = 6'd0;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_pad    = r_pad;
        n_closed = r_closed;
        n_err    = r_err;
        job_acc  = r_acc;
        if (r_err == ST_OK) begin
            if (r_closed) begin
                n_err = ST_PADDING;
            end else if (i_sym.symbol == CH_PAD) begin
                if (m == MODE_B16) begin
                    n_err = ST_PADDING;
                end else if (cnt1 >= glen) begin
                    d = (np1 >= glen) ? 4'd0 : glen - np1;
                    if (d == 4'd0) n_err = ST_PADDING;
                    else           total = 6'(d * bits);
                    n_cnt    = 3'd0;
                    n_pad    = 3'd0;
                    n_closed = 1'b1;
                end else begin
                    n_cnt = cnt1[2:0];
                    n_pad = np1[2:0];
                end
            end else if (r_pad != 3'd0) begin
                n_err = ST_PADDING;
            end else if (!lk[6]) begin
                n_err = ST_INVALID;
            end else begin
                job_acc = (r_acc << bits) | {{(AccW-6){1'b0}}, lk[5:0]};
                n_acc   = job_acc;
                if (cnt1 >= glen) begin
                    total = 6'(glen * bits);
                    n_cnt = 3'd0;
                end else begin
                    n_cnt = cnt1[2:0];
                end
            end
        end
        nb = total[5:3];
        if (nb != 3'd0) n_acc = '0;
        if (i_sym.last_symbol && n_err == ST_OK && (n_cnt != 3'd0 || n_pad != 3'd0))
            n_err = ST_LENGTH;
    end

    assign o_push       = take && (nb != 3'd0 || i_sym.last_symbol);
    assign o_job.acc    = job_acc;
    assign o_job.total  = total;
    assign o_job.nbytes = nb;
    assign o_job.last   = i_sym.last_symbol;
    assign o_job.status = n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_B64;
            r_acc    <= '0;
            r_cnt    <= 3'd0;
            r_pad    <= 3'd0;
            r_closed <= 1'b0;
            r_err    <= ST_OK;
        end else if (i_cfg.valid) begin
            // Abort any message in progress.
            r_mode   <= i_cfg.alphabet_mode;
            r_acc    <= '0;
            r_cnt    <= 3'd0;
            r_pad    <= 3'd0;
            r_closed <= 1'b0;
            r_err    <= ST_OK;
        end else if (take) begin
            if (i_sym.last_symbol) begin
                r_acc    <= '0;
                r_cnt    <= 3'd0;
                r_pad    <= 3'd0;
                r_closed <= 1'b0;
                r_err    <= ST_OK;
            end else begin
                r_acc    <= n_acc;
                r_cnt    <= n_cnt;
                r_pad    <= n_pad;
                r_closed <= n_closed;
                r_err    <= n_err;
            end
        end
    end

endmodule

// File: rtl/core/bnd_queue.sv
// Job queue between front and back.
module bnd_queue
    import bnd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_head,
    output t_qstat o_qstat
);

    t_job             r_mem [QDepth];
    logic [QPtrW-1:0] r_wp;
    logic [QPtrW-1:0] r_rp;
    logic [QCntW-1:0] r_cnt;

    assign o_head        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == QCntW'(QDepth));
    assign o_qstat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/core/bnd_back.sv
// Back end: unpacks jobs into registered byte results, one per cycle while o_res.ready.
module bnd_back
    import bnd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  t_qstat      i_qstat,
    output logic        o_pop,
    bnd_res_if.source   o_res
);

    logic            r_ov;
    logic [7:0]      r_byte;
    logic            r_bv;
    logic            r_rl;
    logic            r_me;
    t_status         r_st;
    logic            r_busy;
    logic [AccW-1:0] r_sh;
    logic [2:0]      r_rem;
    logic            r_last;
    t_status         r_status;

    logic            n_ov;
    logic [7:0]      n_byte;
    logic            n_bv;
    logic            n_rl;
    logic            n_me;
    t_status         n_st;
    logic            n_busy;
    logic [AccW-1:0] n_sh;
    logic [2:0]      n_rem;
    logic            n_last;
    t_status         n_status;

    logic            adv;
    logic            fin;
    logic [AccW-1:0] al;

    assign o_res.valid       = r_ov;
    assign o_res.data_byte   = r_byte;
    assign o_res.byte_valid  = r_bv;
    assign o_res.run_last    = r_rl;
    assign o_res.message_end = r_me;
    assign o_res.status      = r_st;

    assign adv = !r_ov || o_res.ready;
    // Left-align the group so its first byte sits at the top.
    assign al  = i_head.acc << (6'(AccW) - i_head.total);

    always_comb begin
        n_ov     = r_ov && !o_res.ready;
        n_byte   = r_byte;
        n_bv     = r_bv;
        n_rl     = r_rl;
        n_me     = r_me;
        n_st     = r_st;
        n_busy   = r_busy;
        n_sh     = r_sh;
        n_rem    = r_rem;
        n_last   = r_last;
        n_status = r_status;
        o_pop    = 1'b0;
        fin      = 1'b0;
        if (adv) begin
            if (r_busy) begin
                fin    = (r_rem == 3'd1);
                n_ov   = 1'b1;
                n_byte = r_sh[AccW-1 -: 8];
                n_bv   = 1'b1;
                n_rl   = fin;
                n_me   = fin && r_last;
                n_st   = (fin && r_last) ? r_status : ST_OK;
                n_sh   = r_sh << 8;
                n_rem  = r_rem - 3'd1;
                n_busy = !fin;
            end else if (!i_qstat.empty) begin
                o_pop = 1'b1;
                n_ov  = 1'b1;
                if (i_head.nbytes == 3'd0) begin
                    // Bare message end
                    n_byte = 8'd0;
                    n_bv   = 1'b0;
                    n_rl   = 1'b1;
                    n_me   = 1'b1;
                    n_st   = i_head.status;
                end else begin
                    fin      = (i_head.nbytes == 3'd1);
                    n_byte   = al[AccW-1 -: 8];
                    n_bv     = 1'b1;
                    n_rl     = fin;
                    n_me     = fin && i_head.last;
                    n_st     = (fin && i_head.last) ? i_head.status : ST_OK;
                    n_busy   = !fin;
                    n_sh     = al << 8;
                    n_rem    = i_head.nbytes - 3'd1;
                    n_last   = i_head.last;
                    n_status = i_head.status;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            r_ov   <= n_ov;
            r_busy <= n_busy;
        end
        r_byte   <= n_byte;
        r_bv     <= n_bv;
        r_rl     <= n_rl;
        r_me     <= n_me;
        r_st     <= n_st;
        r_sh     <= n_sh;
        r_rem    <= n_rem;
        r_last   <= n_last;
        r_status <= n_status;
    end

endmodule

// File: rtl/core/base_n_decoder.sv
// Top level of the RFC 4648 base16/32/32hex/64/64url text decoder.
// The front end takes one character per cycle while the job queue is not full and no
// mode write is pending; the back end emits one result per cycle while the receiver is
// ready, one per byte of a job, so a full base32 group gives 5 byte results. A 4-entry
// job queue between them absorbs bursts, and each result leaves an output register.
// Reset clears all message state and sets the mode to base64; a mode write also clears it.
module base_n_decoder
    import bnd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bnd_sym_if.sink    i_sym,
    bnd_cfg_if.sink    i_cfg,
    bnd_res_if.source  o_res
);

    logic   w_push;
    logic   w_pop;
    t_job   w_job;
    t_job   w_head;
    t_qstat w_qstat;

    bnd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sym   (i_sym),
        .i_cfg   (i_cfg),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    bnd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    bnd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("job popped from an empty queue");

    a_bare_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.byte_valid) |->
            (o_res.message_end && o_res.run_last && o_res.data_byte == 8'd0))
        else $error("result without a byte is not a message end");

    a_cfg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid |-> !(i_sym.valid && i_sym.ready))
        else $error("item accepted during a mode write");

endmodule

// File: tb/base_n_decoder_tb.sv
// Self-checking base-N text decoder testbench: directed and random text against a predictor.
`timescale 1ns / 100ps

module base_n_decoder_tb;
    import bnd_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int RandomChars = 500;
    localparam int PhaseChars = 60;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } t_text_char;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       run_last;
        logic       message_end;
        t_status    status;
    } t_byte_result;

    typedef enum {
        DMG_SWAP_BYTE,
        DMG_DROP_TAIL,
        DMG_EXTRA_CHAR,
        DMG_STRAY_PAD,
        DMG_STRIP_PADS,
        DMG_PAD_GROUP
    } t_damage;

    logic i_clk;
    logic i_rst_n;

    bnd_sym_if sym_ch ();
    bnd_res_if res_ch ();
    bnd_cfg_if cfg_ch ();

    base_n_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sym   (sym_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // Decoder state as predicted
    logic [2:0]      cur_mode;
    logic [AccW-1:0] acc_bits;
    int              grp_cnt;
    int              pad_cnt;
    logic            pad_closed;
    t_status         msg_err;

    t_text_char   chars_to_send [$];
    t_byte_result byte_results_due [$];
    logic [7:0]   msg_text [$];

    t_text_char   next_char;
    t_byte_result want;
    int           cycle_count = 0;
    int           chars_accepted = 0;
    int           mismatches = 0;
    logic         hold_results;
    logic         quiet;

    // Drop random idling on both sides for one long stretch
    assign quiet = (cycle_count >= 900) && (cycle_count < 1500);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("%0t: timeout, %0d results still due", $time, byte_results_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [2:0] coded_mode(input logic [2:0] m);
        return (m > MODE_B64URL) ? MODE_B64 : m;
    endfunction

    function automatic int symbol_bits(input logic [2:0] m);
        if (m == MODE_B16) return 4;
        if (m == MODE_B32 || m == MODE_B32HEX) return 5;
        return 6;
    endfunction

    function automatic int group_chars(input logic [2:0] m);
        if (m == MODE_B16) return 2;
        if (m == MODE_B32 || m == MODE_B32HEX) return 8;
        return 4;
    endfunction

    // Symbol value of a character, -1 when outside the alphabet
    function automatic int symbol_value(input logic [2:0] m, input logic [7:0] c);
        if (c[7]) return -1;
        case (m)
            MODE_B16: begin
                if (c >= "0" && c <= "9") return c - "0";
                if (c >= "A" && c <= "F") return c - "A" + 10;
            end
            MODE_B32: begin
                if (c >= "A" && c <= "Z") return c - "A";
                if (c >= "2" && c <= "7") return c - "2" + 26;
            end
            MODE_B32HEX: begin
                if (c >= "0" && c <= "9") return c - "0";
                if (c >= "A" && c <= "V") return c - "A" + 10;
            end
            default: begin
                if (c >= "A" && c <= "Z") return c - "A";
                if (c >= "a" && c <= "z") return c - "a" + 26;
                if (c >= "0" && c <= "9") return c - "0" + 52;
                if (m == MODE_B64URL) begin
                    if (c == CH_DASH) return 62;
                    if (c == CH_UNDER) return 63;
                end else begin
                    if (c == CH_PLUS) return 62;
                    if (c == CH_SLASH) return 63;
                end
            end
        endcase
        return -1;
    endfunction

    function automatic logic [7:0] symbol_char(input logic [2:0] m, input int v);
        case (m)
            MODE_B16, MODE_B32HEX: return (v < 10) ? 8'("0" + v) : 8'("A" + v - 10);
            MODE_B32: return (v < 26) ? 8'("A" + v) : 8'("2" + v - 26);
            default: begin
                if (v < 26) return 8'("A" + v);
                if (v < 52) return 8'("a" + v - 26);
                if (v < 62) return 8'("0" + v - 52);
                if (m == MODE_B64URL) return (v == 62) ? CH_DASH : CH_UNDER;
                return (v == 62) ? CH_PLUS : CH_SLASH;
            end
        endcase
    endfunction

    task automatic clear_message();
        acc_bits = '0;
        grp_cnt = 0;
        pad_cnt = 0;
        pad_closed = 1'b0;
        msg_err = ST_OK;
    endtask

    // Advance the predicted state by one character and queue the results it causes
    task automatic decode_symbol(input logic [7:0] c, input logic last);
        logic [2:0]   m;
        int           bits, glen, v, cnt, np, d, total, nb, n, j;
        logic [7:0]   out_bytes [0:4];
        t_byte_result r;
        m = coded_mode(cur_mode);
        bits = symbol_bits(m);
        glen = group_chars(m);
        nb = 0;
        total = 0;
        if (msg_err == ST_OK) begin
            if (pad_closed) begin
                msg_err = ST_PADDING;
            end else if (c == CH_PAD) begin
                if (m == MODE_B16) begin
                    msg_err = ST_PADDING;
                end else begin
                    np = pad_cnt + 1;
                    cnt = grp_cnt + 1;
                    if (cnt >= glen) begin
                        d = (np >= glen) ? 0 : glen - np;
                        if (d == 0) begin
                            msg_err = ST_PADDING;
                        end else begin
                            total = d * bits;
                            nb = total / 8;
                        end
                        cnt = 0;
                        np = 0;
                        pad_closed = 1'b1;
                    end
                    pad_cnt = np;
                    grp_cnt = cnt;
                end
            end else if (pad_cnt != 0) begin
                msg_err = ST_PADDING;
            end else begin
                v = symbol_value(m, c);
                if (v < 0) begin
                    msg_err = ST_INVALID;
                end else begin
                    cnt = grp_cnt + 1;
                    acc_bits = (acc_bits << bits) | AccW'(v);
                    if (cnt >= glen) begin
                        total = glen * bits;
                        nb = total / 8;
                        cnt = 0;
                    end
                    grp_cnt = cnt;
                end
            end
            for (j = 0; j < nb; j++)
                out_bytes[j] = 8'(acc_bits >> (total - 8 * (j + 1)));
            if (nb != 0)
                acc_bits = '0;
        end
        if (last && msg_err == ST_OK && (grp_cnt != 0 || pad_cnt != 0))
            msg_err = ST_LENGTH;

        n = (last && nb == 0) ? 1 : nb;
        for (j = 0; j < n; j++) begin
            r.data_byte = (j < nb) ? out_bytes[j] : 8'h00;
            r.byte_valid = (j < nb);
            r.run_last = (j == n - 1);
            r.message_end = last && (j == n - 1);
            r.status = (last && j == n - 1) ? msg_err : ST_OK;
            byte_results_due.push_back(r);
        end
        if (last)
            clear_message();
    endtask

    // Character driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sym_ch.valid <= 1'b0;
        end else begin
            if (sym_ch.valid && sym_ch.ready) begin
                decode_symbol(sym_ch.symbol, sym_ch.last_symbol);
                chars_accepted <= chars_accepted + 1;
            end
            if (!sym_ch.valid || sym_ch.ready) begin
                if (chars_to_send.size() != 0 && (quiet || $urandom_range(99) >= 24)) begin
                    next_char = chars_to_send.pop_front();
                    sym_ch.valid <= 1'b1;
                    sym_ch.symbol <= next_char.symbol;
                    sym_ch.last_symbol <= next_char.last;
                end else begin
                    sym_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (byte_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result byte=%02h valid=%0d run_last=%0d end=%0d status=%0d",
                             $time, res_ch.data_byte, res_ch.byte_valid, res_ch.run_last,
                             res_ch.message_end, res_ch.status);
                end else begin
                    want = byte_results_due.pop_front();
                    if (res_ch.data_byte !== want.data_byte
                        || res_ch.byte_valid !== want.byte_valid
                        || res_ch.run_last !== want.run_last
                        || res_ch.message_end !== want.message_end
                        || res_ch.status !== want.status) begin
                        mismatches++;
                        // byte/valid/run_last/end/status
                        $display("%0t: expected %02h/%0d/%0d/%0d/%0d got %02h/%0d/%0d/%0d/%0d",
                                 $time, want.data_byte, want.byte_valid, want.run_last,
                                 want.message_end, want.status, res_ch.data_byte,
                                 res_ch.byte_valid, res_ch.run_last, res_ch.message_end,
                                 res_ch.status);
                    end
                end
            end
            res_ch.ready <= !hold_results && (quiet || $urandom_range(99) >= 24);
        end
    end

    // Hold off the receiver once while plenty of text is still waiting to go in
    initial begin
        hold_results = 1'b0;
        do @(negedge i_clk); while (chars_accepted < 120 || chars_to_send.size() < 40);
        hold_results = 1'b1;
        repeat (300) @(negedge i_clk);
        hold_results = 1'b0;
    end

    task automatic push_char(input logic [7:0] c, input logic last);
        t_text_char t;
        t.symbol = c;
        t.last = last;
        chars_to_send.push_back(t);
    endtask

    task automatic queue_string(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    task automatic queue_text();
        if (msg_text.size() == 0)
            msg_text.push_back(8'($urandom_range(255)));
        for (int i = 0; i < msg_text.size(); i++)
            push_char(msg_text[i], i == msg_text.size() - 1);
    endtask

    // Encode random bytes as well-formed padded text; spare bits are random
    task automatic build_text(input logic [2:0] mode, input int nbytes);
        logic [2:0]      m;
        logic [AccW-1:0] v;
        int              bits, glen, gbytes, left, k, d, spare, j;
        m = coded_mode(mode);
        bits = symbol_bits(m);
        glen = group_chars(m);
        gbytes = glen * bits / 8;
        msg_text.delete();
        left = nbytes;
        while (left > 0) begin
            k = (left < gbytes) ? left : gbytes;
            v = '0;
            for (j = 0; j < k; j++)
                v = (v << 8) | AccW'($urandom_range(255));
            d = (k * 8 + bits - 1) / bits;
            spare = d * bits - k * 8;
            v = v << spare;
            if (spare != 0)
                v = v | AccW'($urandom_range((1 << spare) - 1));
            for (j = 0; j < d; j++)
                msg_text.push_back(symbol_char(m, int'(v >> ((d - 1 - j) * bits))
                                                  & ((1 << bits) - 1)));
            for (j = d; j < glen; j++)
                msg_text.push_back(CH_PAD);
            left -= k;
        end
    endtask

    task automatic damage_text(input logic [2:0] mode);
        logic [2:0] m;
        int         pos;
        m = coded_mode(mode);
        pos = $urandom_range(msg_text.size() - 1);
        case (t_damage'($urandom_range(DMG_PAD_GROUP)))
            DMG_SWAP_BYTE: msg_text[pos] = 8'($urandom_range(255));
            DMG_DROP_TAIL: if (msg_text.size() > 1) void'(msg_text.pop_back());
            DMG_EXTRA_CHAR: msg_text.push_back($urandom_range(1) ? CH_PAD :
                symbol_char(m, $urandom_range((1 << symbol_bits(m)) - 1)));
            DMG_STRAY_PAD: msg_text[pos] = CH_PAD;
            DMG_STRIP_PADS: begin
                while (msg_text.size() > 1 && msg_text[msg_text.size() - 1] == CH_PAD)
                    void'(msg_text.pop_back());
            end
            default: repeat (group_chars(m)) msg_text.push_back(CH_PAD);
        endcase
    endtask

    task automatic noise_text(input logic [2:0] mode);
        logic [2:0] m;
        int         pick;
        m = coded_mode(mode);
        msg_text.delete();
        repeat ($urandom_range(12, 1)) begin
            pick = $urandom_range(9);
            if (pick < 5)
                msg_text.push_back(symbol_char(m, $urandom_range((1 << symbol_bits(m)) - 1)));
            else if (pick < 7)
                msg_text.push_back(CH_PAD);
            else
                msg_text.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (chars_to_send.size() != 0 || sym_ch.valid || byte_results_due.size() != 0);
        // let a character that causes no result drain from the pipeline
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic [2:0] m);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.alphabet_mode <= m;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cur_mode = m;
        clear_message();
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        logic [2:0] mode;
        int         random_chars, phase_chars, kind, nbytes;
        i_rst_n = 1'b0;
        sym_ch.valid = 1'b0;
        sym_ch.symbol = 8'h00;
        sym_ch.last_symbol = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.alphabet_mode = MODE_B64;
        res_ch.ready = 1'b0;
        cur_mode = MODE_B64;
        clear_message();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Base64 from reset: top symbols with padding, zero code, short group,
        // data after a closed padded group
        queue_string("/+9=");
        push_char(8'h00, 1'b1);
        queue_string("A");
        queue_string("AA==A");
        wait_idle();
        // Base16: top digit, padding, lower case then a high code
        write_mode(MODE_B16);
        queue_string("F0");
        queue_string("=");
        push_char("a", 1'b0);
        push_char(8'hFF, 1'b1);
        wait_idle();
        write_mode(MODE_B64URL);
        queue_string("-_==");
        wait_idle();
        // Unused mode value decodes as base64
        write_mode(3'd7);
        queue_string("+/A=");
        wait_idle();
        write_mode(MODE_B32HEX);
        queue_string("V");
        wait_idle();

        random_chars = 0;
        while (random_chars < RandomChars) begin
            mode = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            write_mode(mode);
            phase_chars = 0;
            while (phase_chars < PhaseChars) begin
                kind = $urandom_range(9);
                nbytes = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
                if (kind < 9)
                    build_text(mode, nbytes);
                if (kind >= 6 && kind < 9)
                    damage_text(mode);
                if (kind == 9)
                    noise_text(mode);
                phase_chars += msg_text.size();
                queue_text();
            end
            random_chars += phase_chars;
            wait_idle();
        end

        repeat (20) @(negedge i_clk);
        if (byte_results_due.size() != 0) begin
            mismatches += byte_results_due.size();
            $display("%0t: %0d expected results never arrived", $time, byte_results_due.size());
        end
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
